// ===== src/wdtfs_pkg.sv =====
// Shared codes, constants and result type for the watchdog timer with feed sequence.
package wdtfs_pkg;

  localparam int unsigned DataWidth = 32;

  // Command codes carried by one input item.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // Register select codes.
  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_FEED    = 2'd2;
  localparam logic [1:0] REG_TIMER   = 2'd3;

  // Bit positions inside the mode register.
  localparam int unsigned MODE_EN_BIT  = 0;
  localparam int unsigned MODE_RST_BIT = 1;
  localparam int unsigned MODE_TOF_BIT = 2;
  localparam int unsigned MODE_INT_BIT = 3;

  // Feed sequence bytes.
  localparam logic [7:0] FEED_FIRST  = 8'hAA;
  localparam logic [7:0] FEED_SECOND = 8'h55;

  // Reset value of the timeout constant and the counter.
  localparam logic [7:0] COUNT_RESET = 8'hFF;

  typedef struct packed {
    logic [DataWidth-1:0] read_value;
    logic                 irq_out;
    logic                 reset_request;
  } wdtfs_res_t;

endpackage

// ===== src/watchdog_timer_with_feed_sequence_core.sv =====
// Top level of the watchdog timer with feed sequence: handshake and result register.
// The result of an item is registered and valid in the cycle after it is accepted.
// Throughput: one item per cycle, set by the single state update in the control logic.
// The input stalls only while a result is held and the output side stalls.
// Reset (rst_ni, asynchronous, active low) clears all flags, the feed sequence and the
// run state, loads 0xFF into the timeout constant and the counter, and empties the output.
module watchdog_timer_with_feed_sequence_core #(
  parameter int unsigned PRESCALE    = 4,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      cmd_i,
  input  logic [1:0]                      reg_sel_i,
  input  logic [wdtfs_pkg::DataWidth-1:0] write_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [wdtfs_pkg::DataWidth-1:0] read_value_o,
  output logic                            irq_out_o,
  output logic                            reset_request_o
);
  import wdtfs_pkg::*;

  logic       in_accept;
  logic       out_valid_q;
  wdtfs_res_t res;
  wdtfs_res_t res_q;

  // The result register can take a new item whenever it is empty or its
  // current item leaves in this same cycle, so items flow back to back.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // All state of the watchdog lives here; its result is computed in the
  // cycle of acceptance and captured below.
  wdtfs_ctrl #(
    .PRESCALE   (PRESCALE),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .cmd_i        (cmd_i),
    .reg_sel_i    (reg_sel_i),
    .write_value_i(write_value_i),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Payload holds while a result is stalled.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_value_o    = res_q.read_value;
  assign irq_out_o       = res_q.irq_out;
  assign reset_request_o = res_q.reset_request;

endmodule

// ===== src/wdtfs_ctrl.sv =====
// Watchdog state registers and the per-item update and result logic.
module wdtfs_ctrl #(
  parameter int unsigned PRESCALE    = 4,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [1:0]                      cmd_i,
  input  logic [1:0]                      reg_sel_i,
  input  logic [wdtfs_pkg::DataWidth-1:0] write_value_i,
  output wdtfs_pkg::wdtfs_res_t           res_o
);
  import wdtfs_pkg::*;

  localparam int unsigned PsWidth = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;
  localparam logic [PsWidth-1:0] PsLast = PsWidth'(PRESCALE - 1);

  logic                   en_q, en_d;
  logic                   rsten_q, rsten_d;
  logic                   tof_q, tof_d;
  logic                   int_q, int_d;
  logic                   armed_q, armed_d;
  logic                   run_q, run_d;
  logic [COUNT_WIDTH-1:0] reload_q, reload_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [PsWidth-1:0]     ps_q, ps_d;
  logic                   fire;
  logic [7:0]             feed_byte;

  assign feed_byte = write_value_i[7:0];

  always_comb begin
    en_d     = en_q;
    rsten_d  = rsten_q;
    tof_d    = tof_q;
    int_d    = int_q;
    armed_d  = armed_q;
    run_d    = run_q;
    reload_d = reload_q;
    cnt_d    = cnt_q;
    ps_d     = ps_q;
    fire     = 1'b0;
    res_o.read_value = '0;

    unique case (cmd_i)
      CMD_TICK: begin
        if (run_q) begin
          if (ps_q == PsLast) begin
            ps_d = '0;
            if (cnt_q == '0) begin
              fire = 1'b1;
            end else begin
              cnt_d = cnt_q - 1'b1;
            end
          end else begin
            ps_d = ps_q + 1'b1;
          end
        end
      end
      CMD_WRITE: begin
        unique case (reg_sel_i)
          REG_MODE: begin
            en_d    = en_q | write_value_i[MODE_EN_BIT];
            rsten_d = rsten_q | write_value_i[MODE_RST_BIT];
            if (!write_value_i[MODE_TOF_BIT]) begin
              tof_d = 1'b0;
            end
          end
          REG_TIMEOUT: reload_d = write_value_i[COUNT_WIDTH-1:0];
          REG_FEED: begin
            if (!armed_q) begin
              armed_d = (feed_byte == FEED_FIRST);
            end else begin
              armed_d = 1'b0;
              if (feed_byte == FEED_SECOND) begin
                if (en_q) begin
                  cnt_d = reload_q;
                  ps_d  = '0;
                  run_d = 1'b1;
                end
              end else if (run_q) begin
                fire = 1'b1;
              end
            end
          end
          REG_TIMER: ;
          default: ;
        endcase
      end
      CMD_READ: begin
        unique case (reg_sel_i)
          REG_MODE: begin
            res_o.read_value[MODE_EN_BIT]  = en_q;
            res_o.read_value[MODE_RST_BIT] = rsten_q;
            res_o.read_value[MODE_TOF_BIT] = tof_q;
            res_o.read_value[MODE_INT_BIT] = int_q;
          end
          REG_TIMEOUT: res_o.read_value = DataWidth'(reload_q);
          REG_TIMER:   res_o.read_value = DataWidth'(cnt_q);
          REG_FEED:    ;
          default:     ;
        endcase
      end
      CMD_NOP: ;
      default: ;
    endcase

    // A timeout raises both flags and restarts the count from the constant.
    if (fire) begin
      tof_d = 1'b1;
      int_d = 1'b1;
      cnt_d = reload_q;
      ps_d  = '0;
    end

    res_o.irq_out       = int_d;
    res_o.reset_request = fire & rsten_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      rsten_q  <= 1'b0;
      tof_q    <= 1'b0;
      int_q    <= 1'b0;
      armed_q  <= 1'b0;
      run_q    <= 1'b0;
      reload_q <= COUNT_WIDTH'(COUNT_RESET);
      cnt_q    <= COUNT_WIDTH'(COUNT_RESET);
      ps_q     <= '0;
    end else if (accept_i) begin
      en_q     <= en_d;
      rsten_q  <= rsten_d;
      tof_q    <= tof_d;
      int_q    <= int_d;
      armed_q  <= armed_d;
      run_q    <= run_d;
      reload_q <= reload_d;
      cnt_q    <= cnt_d;
      ps_q     <= ps_d;
    end
  end

endmodule

// ===== sim/wdtfs_checker.sv =====
// Watchdog checker: predicts each result from the accepted items and compares it with the block.
module wdtfs_checker #(
  parameter int unsigned Prescale   = 4,
  parameter int unsigned CountWidth = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [1:0]                      cmd_i,
  input  logic [1:0]                      reg_sel_i,
  input  logic [wdtfs_pkg::DataWidth-1:0] write_value_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [wdtfs_pkg::DataWidth-1:0] read_value_i,
  input  logic                            irq_out_i,
  input  logic                            reset_request_i,
  output int unsigned                     accepted_o,
  output int unsigned                     pending_o,
  output int unsigned                     mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import wdtfs_pkg::*;

  localparam logic [DataWidth-1:0] CountMask = {DataWidth{1'b1}} >> (DataWidth - CountWidth);

  // Model copy of the watchdog state.
  logic                 wd_en;
  logic                 wd_rst_en;
  logic                 wd_tof;
  logic                 wd_irq;
  logic [DataWidth-1:0] wd_reload;
  logic [DataWidth-1:0] wd_count;
  int unsigned          wd_presc;
  logic                 wd_armed;
  logic                 wd_running;

  wdtfs_res_t  due_results[$];
  int unsigned error_total;

  assign mismatches_o = error_total;

  task automatic report_mismatch(input string what, input logic [DataWidth-1:0] got,
                                 input logic [DataWidth-1:0] want);
    $display("%0t wdtfs_checker: %s: got %h, expected %h", $time, what, got, want);
    error_total++;
  endtask

  function automatic logic raise_timeout();
    wd_tof   = 1'b1;
    wd_irq   = 1'b1;
    wd_count = wd_reload & CountMask;
    wd_presc = 0;
    return wd_rst_en;
  endfunction

  function automatic logic take_feed(input logic [7:0] feed_byte);
    if (!wd_armed) begin
      if (feed_byte == FEED_FIRST) wd_armed = 1'b1;
      return 1'b0;
    end
    wd_armed = 1'b0;
    if (feed_byte == FEED_SECOND) begin
      if (wd_en) begin
        wd_count   = wd_reload & CountMask;
        wd_presc   = 0;
        wd_running = 1'b1;
      end
      return 1'b0;
    end
    // A broken sequence only bites while the counter runs.
    if (wd_running) return raise_timeout();
    return 1'b0;
  endfunction

  function automatic logic count_tick();
    if (!wd_running) return 1'b0;
    wd_presc++;
    if (wd_presc < Prescale) return 1'b0;
    wd_presc = 0;
    if (wd_count == '0) return raise_timeout();
    wd_count = (wd_count - 1'b1) & CountMask;
    return 1'b0;
  endfunction

  function automatic wdtfs_res_t apply_access(input logic [1:0] cmd, input logic [1:0] sel,
                                              input logic [DataWidth-1:0] value);
    wdtfs_res_t res;
    logic       req;
    res.read_value = '0;
    req            = 1'b0;
    case (cmd)
      CMD_TICK: req = count_tick();
      CMD_WRITE: begin
        case (sel)
          REG_MODE: begin
            if (value[MODE_EN_BIT]) wd_en = 1'b1;
            if (value[MODE_RST_BIT]) wd_rst_en = 1'b1;
            if (!value[MODE_TOF_BIT]) wd_tof = 1'b0;
          end
          REG_TIMEOUT: wd_reload = value & CountMask;
          REG_FEED: req = take_feed(value[7:0]);
          default: ;
        endcase
      end
      CMD_READ: begin
        case (sel)
          REG_MODE: begin
            res.read_value[MODE_EN_BIT]  = wd_en;
            res.read_value[MODE_RST_BIT] = wd_rst_en;
            res.read_value[MODE_TOF_BIT] = wd_tof;
            res.read_value[MODE_INT_BIT] = wd_irq;
          end
          REG_TIMEOUT: res.read_value = wd_reload & CountMask;
          REG_TIMER: res.read_value = wd_count & CountMask;
          default: ;
        endcase
      end
      default: ;
    endcase
    res.irq_out       = wd_irq;
    res.reset_request = req;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wdtfs_res_t want;
    if (!rst_ni) begin
      wd_en       = 1'b0;
      wd_rst_en   = 1'b0;
      wd_tof      = 1'b0;
      wd_irq      = 1'b0;
      wd_reload   = {{(DataWidth-8){1'b0}}, COUNT_RESET} & CountMask;
      wd_count    = {{(DataWidth-8){1'b0}}, COUNT_RESET} & CountMask;
      wd_presc    = 0;
      wd_armed    = 1'b0;
      wd_running  = 1'b0;
      due_results.delete();
      error_total = 0;
      accepted_o <= 0;
      pending_o  <= 0;
    end else begin
      // Results leave before new items enter, since each result is registered after its item.
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing expected", read_value_i, '0);
        end else begin
          want = due_results.pop_front();
          if (read_value_i !== want.read_value)
            report_mismatch("read_value", read_value_i, want.read_value);
          if (irq_out_i !== want.irq_out)
            report_mismatch("irq_out", DataWidth'(irq_out_i), DataWidth'(want.irq_out));
          if (reset_request_i !== want.reset_request)
            report_mismatch("reset_request", DataWidth'(reset_request_i),
                            DataWidth'(want.reset_request));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        due_results.push_back(apply_access(cmd_i, reg_sel_i, write_value_i));
        accepted_o <= accepted_o + 1;
      end
      pending_o <= due_results.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the watchdog timer core: clock, reset, stimulus, stalls and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wdtfs_pkg::*;

  // Every input of the block is known from time zero.
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic [1:0]           cmd_i         = CMD_NOP;
  logic [1:0]           reg_sel_i     = REG_MODE;
  logic [DataWidth-1:0] write_value_i = '0;
  logic                 out_stall_i   = 1'b0;

  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [DataWidth-1:0] read_value_o;
  logic                 irq_out_o;
  logic                 reset_request_o;

  int unsigned accepted;
  int unsigned pending;
  int unsigned mismatches;

  // Number of items handed to the block so far, and the switch that ends all idling
  // for the closing stretch of the run.
  int unsigned items_sent = 0;
  bit          calm_tail  = 1'b0;
  int unsigned stall_left = 0;

  watchdog_timer_with_feed_sequence_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .reg_sel_i      (reg_sel_i),
    .write_value_i  (write_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_value_o   (read_value_o),
    .irq_out_o      (irq_out_o),
    .reset_request_o(reset_request_o)
  );

  // The checker sits beside the block and sees exactly what the block sees.
  wdtfs_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .cmd_i          (cmd_i),
    .reg_sel_i      (reg_sel_i),
    .write_value_i  (write_value_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_value_i   (read_value_o),
    .irq_out_i      (irq_out_o),
    .reset_request_i(reset_request_o),
    .accepted_o     (accepted),
    .pending_o      (pending),
    .mismatches_o   (mismatches)
  );

  // 4 ns clock, high phase first.
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Hard stop: far beyond the slowest correct run, where every item waits out the
  // longest sender gap and every result the longest receiver stall.
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Receiver side: random stall bursts, none in the closing stretch.
  // The stall is driven once per falling edge.
  always @(negedge clk_i) begin
    if (stall_left != 0 && !calm_tail) begin
      out_stall_i <= 1'b1;
      stall_left  = stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
      if (!calm_tail && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 11);
    end
  end

  // Hands one item to the block at a falling edge and returns at the falling edge after
  // the rising edge that took it. Valid stays high on return, so back-to-back items
  // keep it high; a random gap may lower it first.
  task automatic send_item(input logic [1:0] cmd, input logic [1:0] sel,
                           input logic [DataWidth-1:0] value);
    int unsigned seen;
    if (!calm_tail && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    reg_sel_i     <= sel;
    write_value_i <= value;
    seen = accepted;
    do @(negedge clk_i); while (accepted == seen);
    items_sent++;
  endtask

  task automatic send_ticks(input int unsigned count);
    repeat (count) send_item(CMD_TICK, 2'($urandom), $urandom);
  endtask

  // Stops sending until every outstanding result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // Feed write whose low byte is the given sequence byte and whose upper bits are random,
  // since only the low byte matters to the block.
  task automatic send_feed(input logic [7:0] feed_byte);
    logic [DataWidth-1:0] value;
    value       = $urandom;
    value[7:0]  = feed_byte;
    send_item(CMD_WRITE, REG_FEED, value);
  endtask

  initial begin
    int unsigned          pick;
    logic [DataWidth-1:0] value;

    // Reset is held low from time zero and released at a falling edge.
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. The reset contents are read first, including the feed register,
    // which always reads as zero.
    send_item(CMD_READ, REG_MODE, '0);
    send_item(CMD_READ, REG_TIMEOUT, '0);
    send_item(CMD_READ, REG_TIMER, '0);
    send_item(CMD_READ, REG_FEED, '1);
    // The timer value register ignores writes, and the unused command does nothing.
    send_item(CMD_WRITE, REG_TIMER, '1);
    send_item(CMD_READ, REG_TIMER, '0);
    send_item(CMD_NOP, REG_TIMER, '1);
    // A tick does nothing while the counter is stopped.
    send_ticks(1);
    // A complete feed while disabled is swallowed, then a lone stray byte is ignored,
    // then a broken sequence with the counter stopped raises nothing.
    send_feed(FEED_FIRST);
    send_feed(FEED_SECOND);
    send_feed(8'h12);
    send_feed(FEED_FIRST);
    send_feed(8'h00);
    // Short timeout, enable only, so the first timeout comes without a reset request.
    send_item(CMD_WRITE, REG_TIMEOUT, 32'd1);
    send_item(CMD_WRITE, REG_MODE, 32'd1 << MODE_EN_BIT);
    // Another access between the two feed bytes keeps the sequence armed.
    send_feed(FEED_FIRST);
    send_item(CMD_READ, REG_MODE, '0);
    send_feed(FEED_SECOND);
    // Two prescaler periods bring the counter from one to zero and then underflow it.
    send_ticks(8);
    // All ones with the timeout bit low: sets reset-enable and clears the timeout flag.
    send_item(CMD_WRITE, REG_MODE, ~(32'd1 << MODE_TOF_BIT));
    // A second first-byte while running is a bad feed and forces a timeout at once;
    // the following second-byte finds the sequence disarmed.
    send_feed(FEED_FIRST);
    send_feed(FEED_FIRST);
    send_feed(FEED_SECOND);
    send_item(CMD_WRITE, REG_TIMEOUT, '1);
    send_item(CMD_READ, REG_TIMEOUT, '0);

    // The sender holds off until the block has answered everything so far.
    drain_results();

    // Random part. Most traffic is ticks and proper feed sequences with short timeouts,
    // so the counter keeps running down and timing out; the rest is mode writes, reads,
    // broken sequences, timeout writes, drains and plain noise.
    while (items_sent < 1100) begin
      if (items_sent >= 900) calm_tail = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_ticks($urandom_range(1, 6));
      end else if (pick < 55) begin
        send_feed(FEED_FIRST);
        if ($urandom_range(0, 3) == 0) send_item(CMD_READ, 2'($urandom), $urandom);
        send_feed(FEED_SECOND);
      end else if (pick < 60) begin
        send_feed(FEED_FIRST);
        send_feed(8'($urandom));
      end else if (pick < 65) begin
        send_item(CMD_WRITE, REG_MODE, $urandom);
      end else if (pick < 71) begin
        // Mostly short timeouts, now and then a full-width one.
        if ($urandom_range(0, 9) == 0) value = $urandom;
        else value = $urandom_range(0, 6);
        send_item(CMD_WRITE, REG_TIMEOUT, value);
      end else if (pick < 88) begin
        send_item(CMD_READ, 2'($urandom), $urandom);
      end else if (pick < 89) begin
        drain_results();
      end else begin
        send_item(2'($urandom), 2'($urandom), $urandom);
      end
    end

    // Wait for the last results, then keep watching for anything unexpected to show up.
    drain_results();
    repeat (4) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/wdtfs_pkg.sv
src/wdtfs_ctrl.sv
src/watchdog_timer_with_feed_sequence_core.sv
sim/wdtfs_checker.sv
sim/tb_top.sv
